// ===== sv/sess_pkg.sv =====
`timescale 1ns / 1ps

package sess_pkg;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_VALIDATE = 3'd1;
    localparam logic [2:0] OP_DESTROY  = 3'd2;
    localparam logic [2:0] OP_GET_USER = 3'd3;
    localparam logic [2:0] OP_REAP     = 3'd4;

    localparam logic [31:0] TTL_RESET = 32'd1800;

    // write side of the entry store
    typedef struct packed {
        logic        valid_we;
        logic        valid_d;
        logic        data_we;
        logic        exp_we;
        logic [63:0] tok_hi;
        logic [63:0] tok_lo;
        logic [63:0] user;
        logic [32:0] expiry;
    } sess_wr_t;

    // registered read word of one entry
    typedef struct packed {
        logic        valid;
        logic [63:0] tok_hi;
        logic [63:0] tok_lo;
        logic [63:0] user;
        logic [32:0] expiry;
    } sess_rd_t;

endpackage

// ===== sv/sess_req_if.sv =====
`timescale 1ns / 1ps

interface sess_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] now_time;
    logic [63:0] token_hi;
    logic [63:0] token_lo;
    logic [63:0] user_tag;

    modport source (
        output valid, operation, now_time, token_hi, token_lo, user_tag,
        input  ready
    );

    modport sink (
        input  valid, operation, now_time, token_hi, token_lo, user_tag,
        output ready
    );
endinterface

// ===== sv/sess_rsp_if.sv =====
`timescale 1ns / 1ps

interface sess_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [5:0]  slot_index;
    logic [63:0] found_user;

    modport source (
        output valid, ok, slot_index, found_user,
        input  ready
    );

    modport sink (
        input  valid, ok, slot_index, found_user,
        output ready
    );
endinterface

// ===== sv/sess_store.sv =====
`timescale 1ns / 1ps

module sess_store
    import sess_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output sess_rd_t                   rd_data,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  sess_wr_t                   wr
);

    logic        valid_mem  [ENTRIES];
    logic [63:0] tok_hi_mem [ENTRIES];
    logic [63:0] tok_lo_mem [ENTRIES];
    logic [63:0] user_mem   [ENTRIES];
    logic [32:0] exp_mem    [ENTRIES];

    sess_rd_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.valid_we)
        begin
            valid_mem[wr_addr] <= wr.valid_d;
        end
        if (wr.data_we)
        begin
            tok_hi_mem[wr_addr] <= wr.tok_hi;
            tok_lo_mem[wr_addr] <= wr.tok_lo;
            user_mem[wr_addr]   <= wr.user;
        end
        if (wr.exp_we)
        begin
            exp_mem[wr_addr] <= wr.expiry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.valid  <= valid_mem[rd_addr];
            rd_data_reg.tok_hi <= tok_hi_mem[rd_addr];
            rd_data_reg.tok_lo <= tok_lo_mem[rd_addr];
            rd_data_reg.user   <= user_mem[rd_addr];
            rd_data_reg.expiry <= exp_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/session_table_with_expiry_top.sv =====
`timescale 1ns / 1ps
// Scan: an accepted word starts a scan over the entries that ends in the result word;
//   a hit ends it early, but a reap scans every entry; an unused operation code skips it.
// Flow: a new word is taken only in idle, once the last result has moved to the output
//   register; the store reads one entry per cycle while writing back the one compared.
// Reset: async active low; a clearing pass over every entry then wipes the valid
//   marks, with req.ready low meanwhile; ttl_reg returns to 1800.

module session_table_with_expiry_top
    import sess_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int TOKEN_BITS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    sess_req_if.sink    req,
    sess_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    localparam logic [63:0] LO_MASK = (TOKEN_BITS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << TOKEN_BITS) - 64'd1);
    localparam logic [63:0] HI_MASK = (TOKEN_BITS <= 64) ? 64'd0 :
                                      (TOKEN_BITS >= 128) ? {64{1'b1}} :
                                      ((64'd1 << (TOKEN_BITS - 64)) - 64'd1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [31:0]      ttl_reg, ttl_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [2:0]       op_reg, op_next;
    logic [31:0]      now_reg, now_next;
    logic [63:0]      hi_reg, hi_next;
    logic [63:0]      lo_reg, lo_next;
    logic [63:0]      user_reg, user_next;
    logic [32:0]      exp_new_reg, exp_new_next;
    logic             res_ok_reg, res_ok_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic [63:0]      res_user_reg, res_user_next;
    logic             rsp_ok_reg, rsp_ok_next;
    logic [5:0]       rsp_slot_reg, rsp_slot_next;
    logic [63:0]      rsp_user_reg, rsp_user_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    sess_rd_t         rd;
    sess_wr_t         wr;

    logic             live;
    logic             match;
    logic             finish;

    sess_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd),
        .wr_addr (wr_addr),
        .wr      (wr)
    );

    assign live  = (rd.expiry >= {1'b0, now_reg});
    assign match = rd.valid && (rd.tok_hi == hi_reg) && (rd.tok_lo == lo_reg);

    always_comb
    begin
        state_next     = state_reg;
        ttl_next       = cfg_wr_en ? cfg_wr_data : ttl_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        user_next      = user_reg;
        exp_new_next   = exp_new_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_user_next  = res_user_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_slot_next  = rsp_slot_reg;
        rsp_user_next  = rsp_user_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        wr_addr        = cmp_idx_reg;
        wr.valid_we    = 1'b0;
        wr.valid_d     = 1'b0;
        wr.data_we     = 1'b0;
        wr.exp_we      = 1'b0;
        wr.tok_hi      = hi_reg;
        wr.tok_lo      = lo_reg;
        wr.user        = user_reg;
        wr.expiry      = exp_new_reg;
        finish         = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.valid_we = 1'b1;
                wr_addr     = cnt_reg[IDX_W-1:0];
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = req.operation;
                    now_next      = req.now_time;
                    hi_next       = req.token_hi & HI_MASK;
                    lo_next       = req.token_lo & LO_MASK;
                    user_next     = req.user_tag;
                    exp_new_next  = {1'b0, req.now_time} + {1'b0, ttl_reg};
                    cnt_next      = '0;
                    cmp_vld_next  = 1'b0;
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                    res_user_next = '0;
                    state_next    = (req.operation > OP_REAP) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read entry cnt while comparing entry cmp_idx
                if (cnt_reg != CNT_END)
                begin
                    rd_en        = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                if (cmp_vld_reg)
                begin
                    case (op_reg)
                        OP_CREATE:
                        begin
                            if (!rd.valid || !live)
                            begin
                                wr.valid_we   = 1'b1;
                                wr.valid_d    = 1'b1;
                                wr.data_we    = 1'b1;
                                wr.exp_we     = 1'b1;
                                res_ok_next   = 1'b1;
                                res_slot_next = cmp_idx_reg;
                                finish        = 1'b1;
                            end
                        end
                        OP_VALIDATE:
                        begin
                            if (match)
                            begin
                                if (live)
                                begin
                                    wr.exp_we     = 1'b1;
                                    res_ok_next   = 1'b1;
                                    res_slot_next = cmp_idx_reg;
                                end
                                finish = 1'b1;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (match)
                            begin
                                wr.valid_we   = 1'b1;
                                res_ok_next   = 1'b1;
                                res_slot_next = cmp_idx_reg;
                                finish        = 1'b1;
                            end
                        end
                        OP_GET_USER:
                        begin
                            if (match && live)
                            begin
                                res_ok_next   = 1'b1;
                                res_slot_next = cmp_idx_reg;
                                res_user_next = rd.user;
                                finish        = 1'b1;
                            end
                        end
                        OP_REAP:
                        begin
                            if (rd.valid && !live)
                            begin
                                wr.valid_we = 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase

                    if (cmp_idx_reg == IDX_LAST)
                    begin
                        finish = 1'b1;
                    end
                end

                if (finish)
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = res_ok_reg;
                    rsp_slot_next  = 6'(res_slot_reg);
                    rsp_user_next  = res_user_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ttl_reg       <= TTL_RESET;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ttl_reg       <= ttl_next;
            cnt_reg       <= cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        op_reg       <= op_next;
        now_reg      <= now_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        user_reg     <= user_next;
        exp_new_reg  <= exp_new_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_user_reg <= res_user_next;
        rsp_ok_reg   <= rsp_ok_next;
        rsp_slot_reg <= rsp_slot_next;
        rsp_user_reg <= rsp_user_next;
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = rsp_ok_reg;
    assign rsp.slot_index = rsp_slot_reg;
    assign rsp.found_user = rsp_user_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_SCAN || state_reg == S_DONE))
        else $error("accepted word did not start a scan");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid_we || wr.data_we || wr.exp_we) |->
        (state_reg == S_SCAN || state_reg == S_CLEAR))
        else $error("store written outside scan or clear");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.slot_index == 6'd0 && rsp.found_user == 64'd0))
        else $error("failed result carries nonzero fields");

    a_scan_write_on_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && (wr.valid_we || wr.data_we || wr.exp_we)) |-> cmp_vld_reg)
        else $error("scan write without compared entry");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !rsp_valid_reg) |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("finished result not moved to output");
`endif

endmodule

// ===== sim/session_table_with_expiry_top_test.sv =====
`timescale 1ns / 1ps

module session_table_with_expiry_top_test
    import sess_pkg::*;
;

    localparam int TABLE_SIZE  = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 7;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now;
        logic [63:0] tok_hi;
        logic [63:0] tok_lo;
        logic [63:0] user;
    } req_word_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  slot;
        logic [63:0] user;
    } rsp_word_t;

    class session_book;
        bit          in_use [TABLE_SIZE];
        logic [63:0] tok_hi [TABLE_SIZE];
        logic [63:0] tok_lo [TABLE_SIZE];
        logic [63:0] user   [TABLE_SIZE];
        logic [32:0] expiry [TABLE_SIZE];
        logic [31:0] ttl;
        rsp_word_t   replies_due[$];
        int          mismatches;

        function new();
            ttl = TTL_RESET;
            mismatches = 0;
            foreach (in_use[i])
                in_use[i] = 1'b0;
        endfunction

        function bit token_hit(int i, req_word_t w);
            return in_use[i] && tok_hi[i] == w.tok_hi && tok_lo[i] == w.tok_lo;
        endfunction

        function void note_request(req_word_t w);
            rsp_word_t   r;
            logic [32:0] now33;
            logic [32:0] renewed;
            bit          done;
            r = '0;
            now33 = {1'b0, w.now};
            renewed = now33 + {1'b0, ttl};
            done = 1'b0;
            case (w.op)
                OP_CREATE:
                    for (int i = 0; i < TABLE_SIZE && !done; i++)
                    begin
                        if (!in_use[i] || expiry[i] < now33)
                        begin
                            in_use[i] = 1'b1;
                            tok_hi[i] = w.tok_hi;
                            tok_lo[i] = w.tok_lo;
                            user[i]   = w.user;
                            expiry[i] = renewed;
                            r.ok   = 1'b1;
                            r.slot = 6'(i);
                            done   = 1'b1;
                        end
                    end
                OP_VALIDATE:
                    for (int i = 0; i < TABLE_SIZE && !done; i++)
                    begin
                        if (token_hit(i, w))
                        begin
                            if (expiry[i] >= now33)
                            begin
                                expiry[i] = renewed;
                                r.ok   = 1'b1;
                                r.slot = 6'(i);
                            end
                            done = 1'b1;
                        end
                    end
                OP_DESTROY:
                    for (int i = 0; i < TABLE_SIZE && !done; i++)
                    begin
                        if (token_hit(i, w))
                        begin
                            in_use[i] = 1'b0;
                            r.ok   = 1'b1;
                            r.slot = 6'(i);
                            done   = 1'b1;
                        end
                    end
                OP_GET_USER:
                    for (int i = 0; i < TABLE_SIZE && !done; i++)
                    begin
                        if (token_hit(i, w) && expiry[i] >= now33)
                        begin
                            r.ok   = 1'b1;
                            r.slot = 6'(i);
                            r.user = user[i];
                            done   = 1'b1;
                        end
                    end
                OP_REAP:
                    for (int i = 0; i < TABLE_SIZE; i++)
                    begin
                        if (in_use[i] && expiry[i] < now33)
                        begin
                            in_use[i] = 1'b0;
                            r.ok = 1'b1;
                        end
                    end
                default:
                    ;
            endcase
            replies_due.push_back(r);
        endfunction

        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (replies_due.size() == 0)
            begin
                $error("unexpected word: ok %0d slot_index %0d found_user %h",
                       got.ok, got.slot, got.user);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                mismatches++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.user !== want.user)
            begin
                $error("found_user: expected %h, got %h", want.user, got.user);
                mismatches++;
            end
        endfunction

        // token of a random entry in use, live or expired
        function bit pick_token(output logic [63:0] hi, output logic [63:0] lo);
            int held[$];
            int k;
            hi = '0;
            lo = '0;
            foreach (in_use[i])
                if (in_use[i])
                    held.push_back(i);
            if (held.size() == 0)
                return 1'b0;
            k = held[$urandom_range(0, held.size() - 1)];
            hi = tok_hi[k];
            lo = tok_lo[k];
            return 1'b1;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    sess_req_if req_ch ();
    sess_rsp_if rsp_ch ();

    session_book book;
    int          req_idle_pct;
    int          rsp_stall_pct;
    int          cycle_count;
    logic [31:0] wall_clock;

    logic [31:0] phase_ttl   [PHASES] = '{32'd40, 32'd3, 32'd1800, 32'd0, 32'hffff_ffff,
                                          32'd1, 32'd200};
    int          phase_items [PHASES] = '{250, 200, 300, 150, 150, 150, 200};
    int          idle_table  [4]      = '{0, 55, 0, 28};
    int          stall_table [4]      = '{0, 0, 55, 28};

    session_table_with_expiry_top #(
        .ENTRIES    (TABLE_SIZE),
        .TOKEN_BITS (128)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            book.check_response('{rsp_ch.ok, rsp_ch.slot_index, rsp_ch.found_user});
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input req_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < req_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= w.op;
        req_ch.now_time  <= w.now;
        req_ch.token_hi  <= w.tok_hi;
        req_ch.token_lo  <= w.tok_lo;
        req_ch.user_tag  <= w.user;
        do
            @(posedge clk);
        while (!req_ch.ready);
        book.note_request(w);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (book.replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ttl(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.ttl = value;
    endtask

    task automatic make_random(output req_word_t w);
        int          tick;
        int          pick;
        int          roll;
        logic [63:0] h;
        logic [63:0] l;
        tick = $urandom_range(0, 99);
        if (tick < 4)
            wall_clock = $urandom;
        else if (tick < 8)
            wall_clock = wall_clock + $urandom_range(0, 5000);
        else
            wall_clock = wall_clock + $urandom_range(0, 3);
        w.now    = wall_clock;
        w.user   = rand64();
        w.tok_hi = rand64();
        w.tok_lo = rand64();
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (pick < 30)
        begin
            w.op = OP_CREATE;
            if (roll < 20 && book.pick_token(h, l))
            begin
                w.tok_hi = h;
                w.tok_lo = l;
            end
            else if (roll >= 20 && roll < 24)
            begin
                w.tok_hi = '0;
                w.tok_lo = '0;
            end
            else if (roll >= 24 && roll < 27)
            begin
                w.tok_hi = '1;
                w.tok_lo = '1;
            end
        end
        else if (pick < 92)
        begin
            if (pick < 52)
                w.op = OP_VALIDATE;
            else if (pick < 64)
                w.op = OP_DESTROY;
            else if (pick < 84)
                w.op = OP_GET_USER;
            else
                w.op = OP_REAP;
            if (roll < 85 && book.pick_token(h, l))
            begin
                w.tok_hi = h;
                w.tok_lo = l;
            end
        end
        else if (pick < 95)
            w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else
            w.op = 3'($urandom_range(OP_VALIDATE, OP_GET_USER));
    endtask

    initial
    begin
        req_word_t w;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_CREATE;
        req_ch.now_time  = '0;
        req_ch.token_hi  = '0;
        req_ch.token_lo  = '0;
        req_ch.user_tag  = '0;
        rsp_ch.ready     = 1'b0;
        req_idle_pct     = 0;
        rsp_stall_pct    = 0;
        cycle_count      = 0;
        wall_clock       = '0;
        book = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass at the reset TTL
        send_word('{OP_CREATE,   32'd0,          64'd0, 64'd0, '1});
        send_word('{OP_GET_USER, 32'd0,          64'd0, 64'd0, 64'd5});
        send_word('{OP_VALIDATE, 32'd1800,       64'd0, 64'd0, 64'd0});
        send_word('{OP_CREATE,   32'd100,        '1, '1, 64'd0});
        send_word('{OP_GET_USER, 32'd100,        '1, '1, '1});
        send_word('{OP_CREATE,   32'hffff_ffff,  64'h0123_4567_89ab_cdef,
                    64'hfedc_ba98_7654_3210, 64'h5a5a_a5a5_0f0f_f0f0});
        send_word('{OP_GET_USER, 32'hffff_ffff,  64'h0123_4567_89ab_cdef,
                    64'hfedc_ba98_7654_3210, 64'd0});
        send_word('{OP_VALIDATE, 32'd3601,       64'd0, 64'd0, 64'd0});
        send_word('{OP_GET_USER, 32'd3601,       64'd0, 64'd0, 64'd0});
        send_word('{OP_DESTROY,  32'd3601,       '1, '1, 64'd0});
        send_word('{OP_CREATE,   32'd3601,       64'd0, 64'd0, 64'd77});
        send_word('{OP_CREATE,   32'd3602,       64'd0, 64'd0, 64'd78});
        send_word('{OP_GET_USER, 32'd3602,       64'd0, 64'd0, 64'd0});
        send_word('{OP_DESTROY,  32'd3602,       64'd9, 64'd9, 64'd0});
        send_word('{OP_SPARE_LO, 32'd3602,       64'd0, 64'd0, '1});
        send_word('{OP_SPARE_MID, 32'hffff_ffff, '1, '1, '1});
        send_word('{OP_SPARE_HI, 32'd0,          64'd0, 64'd0, 64'd0});
        send_word('{OP_REAP,     32'd3602,       '1, '1, '1});
        send_word('{OP_REAP,     32'hffff_ffff,  64'd0, 64'd0, 64'd0});
        send_word('{OP_REAP,     32'hffff_ffff,  64'd0, 64'd0, 64'd0});
        send_word('{OP_DESTROY,  32'd0,          64'h0123_4567_89ab_cdef,
                    64'hfedc_ba98_7654_3210, 64'd0});
        send_word('{OP_DESTROY,  32'd0,          64'h0123_4567_89ab_cdef,
                    64'hfedc_ba98_7654_3210, 64'd0});
        drain_replies();

        for (int p = 0; p < PHASES; p++)
        begin
            write_ttl(phase_ttl[p]);
            req_idle_pct  = idle_table[p % 4];
            rsp_stall_pct = stall_table[p % 4];
            for (int n = 0; n < phase_items[p]; n++)
            begin
                make_random(w);
                send_word(w);
            end
            drain_replies();
        end

        repeat (TABLE_SIZE + 8) @(posedge clk);
        if (book.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sess_pkg.sv
sv/sess_req_if.sv
sv/sess_rsp_if.sv
sv/sess_store.sv
sv/session_table_with_expiry_top.sv
sim/session_table_with_expiry_top_test.sv
